@@ sv/escape_sequence_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// Escape sequence decoder assertion macros
// Shared shorthand for the concurrent checks of the decoder modules.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ESD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/esd_pkg.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Types, character constants and classification helpers shared by the decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int LENGTH_WIDTH        = 16;
   localparam int QUEUE_DEPTH         = 2;
   localparam int QUEUE_PTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_V   = 8'h76;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;

   localparam logic [7:0] CTRL_BEL = 8'd7;
   localparam logic [7:0] CTRL_BS  = 8'd8;
   localparam logic [7:0] CTRL_TAB = 8'd9;
   localparam logic [7:0] CTRL_LF  = 8'd10;
   localparam logic [7:0] CTRL_VT  = 8'd11;
   localparam logic [7:0] CTRL_FF  = 8'd12;
   localparam logic [7:0] CTRL_CR  = 8'd13;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_ESC   = 3'd1,
      MODE_OCT1  = 3'd2,
      MODE_OCT2  = 3'd3,
      MODE_HEX   = 3'd4
   } scan_mode_type;

   // One result: a decoded byte, or the end marker of a string.
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } entry_type;

   // Work that one input byte leaves for the back end: one or two results.
   typedef struct packed {
      logic      has_second;
      entry_type first;
      entry_type second;
   } command_type;

   // Optional result from a character seen in plain text mode.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } opt_entry_type;

   function automatic logic is_oct(input logic [7:0] c);
      is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);
   endfunction

   // Returns {digit valid, digit value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         res = {1'b1, c[3:0]};
      end else if (((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
                   ((c >= CH_UPPER_A) && (c <= CH_UPPER_F))) begin
         res = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      hex_digit = res;
   endfunction

   // Returns {known single-byte escape, byte value}.
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] res;
      res = 9'd0;
      if (c == CH_LOWER_A) begin
         res = {1'b1, CTRL_BEL};
      end else if (c == CH_LOWER_B) begin
         res = {1'b1, CTRL_BS};
      end else if (c == CH_LOWER_F) begin
         res = {1'b1, CTRL_FF};
      end else if (c == CH_LOWER_N) begin
         res = {1'b1, CTRL_LF};
      end else if (c == CH_LOWER_R) begin
         res = {1'b1, CTRL_CR};
      end else if (c == CH_LOWER_T) begin
         res = {1'b1, CTRL_TAB};
      end else if (c == CH_LOWER_V) begin
         res = {1'b1, CTRL_VT};
      end else if ((c == CH_QUOTE) || (c == CH_BACKSLASH)) begin
         res = {1'b1, c};
      end
      simple_escape = res;
   endfunction

   // Result of a character handled as plain text.
   function automatic opt_entry_type plain_result(input logic [7:0] c);
      opt_entry_type res;
      res.valid        = (c != CH_BACKSLASH);
      res.entry.is_end = (c == CH_NUL);
      res.entry.data   = (c == CH_NUL) ? CH_NUL : c;
      plain_result = res;
   endfunction

endpackage

@@ sv/esd_front.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder front end
// Runs the escape scanner on each accepted byte and issues result commands.
// ----------------------------------------------------------------------------
module esd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output logic                 cmd_push,
   output esd_pkg::command_type cmd
);

   esd_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]             pending_ff, pending_in;
   logic [4:0]             hex_in;
   logic [8:0]             esc_in;
   esd_pkg::opt_entry_type plain_in;
   logic                   has_first;

   assign hex_in   = esd_pkg::hex_digit(in_byte);
   assign esc_in   = esd_pkg::simple_escape(in_byte);
   assign plain_in = esd_pkg::plain_result(in_byte);

   // Next scanner state.
   always_comb begin
      if (in_byte == esd_pkg::CH_BACKSLASH) begin
         mode_in = esd_pkg::MODE_ESC;
      end else begin
         mode_in = esd_pkg::MODE_PLAIN;
      end
      pending_in = 8'd0;
      unique case (mode_ff)
         esd_pkg::MODE_ESC: begin
            if (in_byte == esd_pkg::CH_NUL) begin
               mode_in = esd_pkg::MODE_PLAIN;
            end else if (esd_pkg::is_oct(in_byte)) begin
               mode_in    = esd_pkg::MODE_OCT1;
               pending_in = {5'd0, in_byte[2:0]};
            end else if (in_byte == esd_pkg::CH_LOWER_X) begin
               mode_in = esd_pkg::MODE_HEX;
            end else begin
               mode_in = esd_pkg::MODE_PLAIN;
            end
         end
         esd_pkg::MODE_OCT1: begin
            if (esd_pkg::is_oct(in_byte)) begin
               mode_in    = esd_pkg::MODE_OCT2;
               pending_in = {pending_ff[4:0], in_byte[2:0]};
            end
         end
         esd_pkg::MODE_OCT2: begin
            if (esd_pkg::is_oct(in_byte)) begin
               mode_in = esd_pkg::MODE_PLAIN;
            end
         end
         esd_pkg::MODE_HEX: begin
            if (hex_in[4]) begin
               mode_in    = esd_pkg::MODE_HEX;
               pending_in = {pending_ff[3:0], hex_in[3:0]};
            end
         end
         default: begin
         end
      endcase
   end

   // Results caused by the current byte.
   always_comb begin
      has_first       = 1'b0;
      cmd.has_second  = 1'b0;
      cmd.first       = '{is_end: 1'b0, data: pending_ff};
      cmd.second      = plain_in.entry;
      unique case (mode_ff)
         esd_pkg::MODE_ESC: begin
            if (in_byte == esd_pkg::CH_NUL) begin
               has_first   = 1'b1;
               cmd.first   = plain_in.entry;
            end else if (esd_pkg::is_oct(in_byte) ||
                         (in_byte == esd_pkg::CH_LOWER_X)) begin
               has_first = 1'b0;
            end else if (esc_in[8]) begin
               has_first  = 1'b1;
               cmd.first  = '{is_end: 1'b0, data: esc_in[7:0]};
            end else begin
               // Unknown escape: keep the backslash and the character.
               has_first      = 1'b1;
               cmd.first      = '{is_end: 1'b0, data: esd_pkg::CH_BACKSLASH};
               cmd.has_second = 1'b1;
               cmd.second     = '{is_end: 1'b0, data: in_byte};
            end
         end
         esd_pkg::MODE_OCT1: begin
            if (!esd_pkg::is_oct(in_byte)) begin
               has_first      = 1'b1;
               cmd.has_second = plain_in.valid;
            end
         end
         esd_pkg::MODE_OCT2: begin
            has_first = 1'b1;
            if (esd_pkg::is_oct(in_byte)) begin
               cmd.first = '{is_end: 1'b0, data: {pending_ff[4:0], in_byte[2:0]}};
            end else begin
               cmd.has_second = plain_in.valid;
            end
         end
         esd_pkg::MODE_HEX: begin
            if (!hex_in[4]) begin
               has_first      = 1'b1;
               cmd.has_second = plain_in.valid;
            end
         end
         default: begin
            has_first = plain_in.valid;
            cmd.first = plain_in.entry;
         end
      endcase
   end

   assign cmd_push = accept && has_first;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= esd_pkg::MODE_PLAIN;
         pending_ff <= 8'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
      end
   end

endmodule

@@ sv/esd_queue.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder command queue
// Small FIFO that decouples the scanner from the result sequencer.
// ----------------------------------------------------------------------------
`include "escape_sequence_decoder_core_macros.svh"

module esd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  esd_pkg::command_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output esd_pkg::command_type head_cmd
);

   localparam int PW = esd_pkg::QUEUE_PTR_WIDTH;
   localparam int CW = esd_pkg::QUEUE_CNT_WIDTH;

   esd_pkg::command_type mem_ff [esd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CW'(esd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(esd_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(esd_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ESD_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !full, "command pushed into full queue")
   `ESD_ASSERT_NOW(a_no_pop_when_empty, clock, reset, pop, head_valid, "command popped from empty queue")
   `ESD_ASSERT_NEXT(a_push_only_grows, clock, reset, do_push && !do_pop, count_ff == CW'($past(count_ff) + 1'b1), "queue fill did not grow on push")

endmodule

@@ sv/esd_back.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder back end
// Sends queued results one per cycle while rsp_ready allows, and keeps the decoded byte count.
// ----------------------------------------------------------------------------
`include "escape_sequence_decoder_core_macros.svh"

module esd_back #(
   parameter int COUNT_WIDTH = esd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  esd_pkg::command_type               head_cmd,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_is_end,
   output logic [esd_pkg::LENGTH_WIDTH-1:0]   rsp_out_length
);

   localparam int LW = esd_pkg::LENGTH_WIDTH;
   localparam int WW = COUNT_WIDTH + LW;

   logic                   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff;
   logic                   end_ff;
   logic [LW-1:0]          length_ff, length_in;
   logic                   load;
   esd_pkg::entry_type     sel;
   logic [WW-1:0]          count_wide;

   assign load       = head_valid && (!valid_ff || rsp_ready);
   assign sel        = phase_ff ? head_cmd.second : head_cmd.first;
   assign pop        = load && (phase_ff || !head_cmd.has_second);
   assign count_wide = WW'(count_ff);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = '0;
      valid_in  = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
         phase_in = !phase_ff && head_cmd.has_second;
         if (sel.is_end) begin
            count_in  = '0;
            length_in = (count_wide > WW'({LW{1'b1}})) ? {LW{1'b1}} : count_wide[LW-1:0];
         end else if (count_ff != {COUNT_WIDTH{1'b1}}) begin
            count_in = COUNT_WIDTH'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= sel.is_end ? esd_pkg::CH_NUL : sel.data;
         end_ff    <= sel.is_end;
         length_ff <= length_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_end     = end_ff;
   assign rsp_out_length = length_ff;

   `ESD_ASSERT_NOW(a_second_needs_head, clock, reset, phase_ff, head_valid && head_cmd.has_second, "second result pending without its command")
   `ESD_ASSERT_NEXT(a_end_clears_count, clock, reset, load && sel.is_end, count_ff == '0, "byte count not cleared after end result")
   `ESD_ASSERT_NOW(a_byte_has_no_length, clock, reset, valid_ff && !end_ff, length_ff == '0 && !(rsp_is_end), "decoded byte carries a length")

endmodule

@@ sv/escape_sequence_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder core
// Streams a zero-terminated string and turns C escape sequences into bytes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_in_byte
//   rsp      out        rsp_valid / rsp_ready  rsp_out_byte, rsp_is_end,
//                                              rsp_out_length
//
// The front end turns each accepted byte into a command combinationally; the
// back end sends one result per cycle while rsp_ready allows, so a byte that
// causes two results (an unknown escape, or a flushed octal or hex value
// followed by a character) holds the single result port longer than others.
// Reset is synchronous and returns the scanner to plain text with an empty
// count and an empty command queue.
// A stalled result channel fills the two-entry command queue and then drops
// req_ready; the scanner keeps its state until the next byte is accepted.
//
// The front end holds the scanner state: the current mode and the octal or
// hex value being collected. For each accepted byte it works out the results
// it causes and pushes them as one command. The back end walks each command,
// loads the output register, and counts the decoded bytes; the end result
// reports that count, saturated to sixteen bits, and clears it.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_core #(
   parameter int COUNT_WIDTH = esd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_is_end,
   output logic [esd_pkg::LENGTH_WIDTH-1:0] rsp_out_length
);

   logic                 accept;
   logic                 cmd_push;
   esd_pkg::command_type cmd;
   logic                 queue_full;
   logic                 cmd_pop;
   logic                 head_valid;
   esd_pkg::command_type head_cmd;

   // A byte is taken whenever the queue has room for the command it may issue.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   esd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   esd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (queue_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   esd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_end     (rsp_is_end),
      .rsp_out_length (rsp_out_length)
   );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Streams zero-terminated strings into the decoder and checks every decoded
// byte and end-of-string length against a cycle-free model of the scanner.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   // Scanner count width of the instance and the limits that follow from it.
   localparam int COUNT_W = esd_pkg::COUNT_WIDTH_DEFAULT;
   localparam int LEN_W   = esd_pkg::LENGTH_WIDTH;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [LEN_W-1:0] LENGTH_MAX = {LEN_W{1'b1}};

   // A character that is neither a known escape nor a digit of any kind.
   localparam logic [7:0] CH_LOWER_Q = 8'h71;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   // Trailing cycles after the last expected result, to catch stray outputs.
   localparam int DRAIN_CYCLES = 20;

   // One expected result. The cycle stamp records when the source byte was
   // transferred, so that a result seen in that same cycle counts as unasked.
   typedef struct {
      logic [7:0]       data;
      logic             is_end;
      logic [LEN_W-1:0] length;
      int unsigned      cyc;
   } decoded_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_in_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic             rsp_is_end;
   logic [LEN_W-1:0] rsp_out_length;

   // Source bytes waiting for the driver, and results waiting for the monitor.
   logic [7:0]         source_bytes [$];
   decoded_result_type decoded_queue [$];

   int unsigned cycle_count = 0;
   int unsigned generated_count = 0;
   int unsigned error_count = 0;
   int unsigned sender_idle_pct = 30;
   int unsigned receiver_idle_pct = 88;

   // Scanner state of the model: mode, collected digit value, decoded count.
   esd_pkg::scan_mode_type scan_state = esd_pkg::MODE_PLAIN;
   logic [7:0]             digit_acc = 8'h00;
   logic [COUNT_W-1:0]     decoded_count = '0;

   escape_sequence_decoder_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_end     (rsp_is_end),
      .rsp_out_length (rsp_out_length)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Scanner model
   // ------------------------------------------------------------------------

   // Queues one decoded byte. The count stops at its maximum instead of wrapping.
   task automatic emit_byte(input logic [7:0] b, input int unsigned cyc);
      decoded_result_type r;
      r.data   = b;
      r.is_end = 1'b0;
      r.length = '0;
      r.cyc    = cyc;
      decoded_queue.push_back(r);
      if (decoded_count != COUNT_MAX) begin
         decoded_count = decoded_count + 1'b1;
      end
   endtask

   // Queues the end-of-string result and clears the scanner for the next string.
   task automatic emit_end(input int unsigned cyc);
      decoded_result_type r;
      r.data   = esd_pkg::CH_NUL;
      r.is_end = 1'b1;
      r.length = (decoded_count > LENGTH_MAX) ? LENGTH_MAX : LEN_W'(decoded_count);
      r.cyc    = cyc;
      decoded_queue.push_back(r);
      scan_state    = esd_pkg::MODE_PLAIN;
      digit_acc     = 8'h00;
      decoded_count = '0;
   endtask

   // A character outside any escape: the terminator ends the string, a
   // backslash opens an escape, and anything else is copied through.
   task automatic take_plain(input logic [7:0] c, input int unsigned cyc);
      scan_state = esd_pkg::MODE_PLAIN;
      if (c == esd_pkg::CH_NUL) begin
         emit_end(cyc);
      end else if (c == esd_pkg::CH_BACKSLASH) begin
         scan_state = esd_pkg::MODE_ESC;
      end else begin
         emit_byte(c, cyc);
      end
   endtask

   // Weight of a hex digit in either case, or -1 for any other character.
   function automatic int hex_weight(input logic [7:0] c);
      if (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_NINE) begin
         return int'(c - esd_pkg::CH_ZERO);
      end else if (c >= esd_pkg::CH_LOWER_A && c <= esd_pkg::CH_LOWER_F) begin
         return int'(c - esd_pkg::CH_LOWER_A) + 10;
      end else if (c >= esd_pkg::CH_UPPER_A && c <= esd_pkg::CH_UPPER_F) begin
         return int'(c - esd_pkg::CH_UPPER_A) + 10;
      end
      return -1;
   endfunction

   // Advances the model by one transferred source byte.
   task automatic decode_byte(input logic [7:0] c, input int unsigned cyc);
      logic oct;
      int   h;
      oct = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_SEVEN);
      h   = hex_weight(c);
      if ((scan_state inside {esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2} && !oct) ||
          (scan_state == esd_pkg::MODE_HEX && h < 0)) begin
         // The character that ends a numeric escape first releases the
         // collected byte and is then handled as plain text.
         emit_byte(digit_acc, cyc);
         digit_acc = 8'h00;
         take_plain(c, cyc);
      end else begin
         case (scan_state)
            esd_pkg::MODE_ESC: begin
               scan_state = esd_pkg::MODE_PLAIN;
               if (c == esd_pkg::CH_NUL) begin
                  // A backslash right before the terminator is dropped.
                  emit_end(cyc);
               end else if (oct) begin
                  digit_acc  = c - esd_pkg::CH_ZERO;
                  scan_state = esd_pkg::MODE_OCT1;
               end else begin
                  case (c)
                     esd_pkg::CH_LOWER_A: emit_byte(esd_pkg::CTRL_BEL, cyc);
                     esd_pkg::CH_LOWER_B: emit_byte(esd_pkg::CTRL_BS, cyc);
                     esd_pkg::CH_LOWER_F: emit_byte(esd_pkg::CTRL_FF, cyc);
                     esd_pkg::CH_LOWER_N: emit_byte(esd_pkg::CTRL_LF, cyc);
                     esd_pkg::CH_LOWER_R: emit_byte(esd_pkg::CTRL_CR, cyc);
                     esd_pkg::CH_LOWER_T: emit_byte(esd_pkg::CTRL_TAB, cyc);
                     esd_pkg::CH_LOWER_V: emit_byte(esd_pkg::CTRL_VT, cyc);
                     esd_pkg::CH_LOWER_X: begin
                        digit_acc  = 8'h00;
                        scan_state = esd_pkg::MODE_HEX;
                     end
                     esd_pkg::CH_QUOTE, esd_pkg::CH_BACKSLASH: emit_byte(c, cyc);
                     default: begin
                        // Unknown escapes keep their backslash.
                        emit_byte(esd_pkg::CH_BACKSLASH, cyc);
                        emit_byte(c, cyc);
                     end
                  endcase
               end
            end
            esd_pkg::MODE_OCT1: begin
               digit_acc  = (digit_acc << 3) + (c - esd_pkg::CH_ZERO);
               scan_state = esd_pkg::MODE_OCT2;
            end
            esd_pkg::MODE_OCT2: begin
               // The third octal digit completes the escape; the value wraps
               // modulo 256.
               emit_byte((digit_acc << 3) + (c - esd_pkg::CH_ZERO), cyc);
               digit_acc  = 8'h00;
               scan_state = esd_pkg::MODE_PLAIN;
            end
            esd_pkg::MODE_HEX: begin
               // Hex escapes take any number of digits and keep the low byte.
               digit_acc = (digit_acc << 4) + h;
            end
            default: take_plain(c, cyc);
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------------

   task automatic push_source(input logic [7:0] b);
      source_bytes.push_back(b);
      generated_count++;
   endtask

   // Hex digit character for a value below 16, in a random case.
   function automatic logic [7:0] hex_char(input int unsigned v);
      if (v < 10) begin
         return esd_pkg::CH_ZERO + 8'(v);
      end
      return ($urandom_range(1) != 0 ? esd_pkg::CH_UPPER_A : esd_pkg::CH_LOWER_A)
             + 8'(v - 10);
   endfunction

   // One random string. Most pieces are plain characters or well formed escapes
   // with random content; a share is raw noise, which may end the string early,
   // and a few strings end in a lone backslash.
   task automatic queue_random_string();
      int unsigned pieces;
      int unsigned pick;
      int unsigned digits;
      logic [7:0]  c;
      pieces = $urandom_range(12, 1);
      for (int unsigned i = 0; i < pieces; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            c = 8'($urandom_range(255, 1));
            push_source(c == esd_pkg::CH_BACKSLASH ? esd_pkg::CH_UPPER_A : c);
         end else if (pick < 55) begin
            push_source(esd_pkg::CH_BACKSLASH);
            case ($urandom_range(8))
               0: push_source(esd_pkg::CH_LOWER_A);
               1: push_source(esd_pkg::CH_LOWER_B);
               2: push_source(esd_pkg::CH_LOWER_F);
               3: push_source(esd_pkg::CH_LOWER_N);
               4: push_source(esd_pkg::CH_LOWER_R);
               5: push_source(esd_pkg::CH_LOWER_T);
               6: push_source(esd_pkg::CH_LOWER_V);
               7: push_source(esd_pkg::CH_QUOTE);
               default: push_source(esd_pkg::CH_BACKSLASH);
            endcase
         end else if (pick < 65) begin
            push_source(esd_pkg::CH_BACKSLASH);
            digits = $urandom_range(3, 1);
            for (int unsigned d = 0; d < digits; d++) begin
               push_source(esd_pkg::CH_ZERO + 8'($urandom_range(7)));
            end
         end else if (pick < 78) begin
            push_source(esd_pkg::CH_BACKSLASH);
            push_source(esd_pkg::CH_LOWER_X);
            digits = $urandom_range(4);
            for (int unsigned d = 0; d < digits; d++) begin
               push_source(hex_char($urandom_range(15)));
            end
         end else if (pick < 88) begin
            // Escape of an arbitrary character, which is mostly unknown.
            push_source(esd_pkg::CH_BACKSLASH);
            push_source(8'($urandom_range(255, 1)));
         end else if (pick < 96) begin
            push_source(8'($urandom_range(255)));
         end else begin
            push_source(esd_pkg::CH_BACKSLASH);
            break;
         end
      end
      push_source(esd_pkg::CH_NUL);
   endtask

   task automatic queue_random_bytes(input int unsigned n);
      int unsigned start;
      start = generated_count;
      while (generated_count - start < n) begin
         queue_random_string();
      end
   endtask

   // Blocks until every queued byte has been transferred and every expected
   // result has come back. The sender keeps offering queued bytes during the wait.
   task automatic wait_drained();
      while (source_bytes.size() != 0 || req_valid || decoded_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic void note_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] ERROR: %s", $realtime, what);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers the next source byte and runs the model on each transfer.
   // The valid bit is written once per edge, so a byte that follows a transfer
   // directly keeps valid high without a glitch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_in_byte, cycle_count);
         end
         if (!req_valid || req_ready) begin
            if (source_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid   <= 1'b1;
               req_in_byte <= source_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: applies back-pressure and checks each result transfer against
   // the oldest expectation that was queued in an earlier cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      decoded_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (decoded_queue.size() == 0 || decoded_queue[0].cyc == cycle_count) begin
               note_error($sformatf("unexpected result: byte %02h end %0b length %0d",
                                    rsp_out_byte, rsp_is_end, rsp_out_length));
            end else begin
               want = decoded_queue.pop_front();
               if (rsp_out_byte !== want.data || rsp_is_end !== want.is_end ||
                   rsp_out_length !== want.length) begin
                  note_error($sformatf(
                     "expected byte %02h end %0b len %0d, got byte %02h end %0b len %0d",
                     want.data, want.is_end, want.length,
                     rsp_out_byte, rsp_is_end, rsp_out_length));
               end
            end
         end
      end
   end

   // Cycle counter with the run's watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence. Queue and idle settings only change at falling edges, so
   // the clocked blocks above never race with them.
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0] directed [];
      directed = '{
         8'hFF, 8'h01,                                      // plain extremes
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_LOWER_A,        // bell
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_QUOTE,          // escaped quote
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_BACKSLASH,      // escaped backslash
         esd_pkg::CH_BACKSLASH, CH_LOWER_Q,                 // unknown escape
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_SEVEN,          // octal wraps ...
         esd_pkg::CH_SEVEN, esd_pkg::CH_SEVEN,              // ... to FF
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_LOWER_X,        // long hex escape ...
         esd_pkg::CH_LOWER_A, esd_pkg::CH_UPPER_F,
         esd_pkg::CH_NINE, esd_pkg::CH_BACKSLASH,           // ... ended by an escape
         esd_pkg::CH_ZERO, esd_pkg::CH_NUL,                 // octal flushed by the end
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_NUL,            // lone trailing backslash
         esd_pkg::CH_BACKSLASH, esd_pkg::CH_LOWER_X,        // empty hex escape
         esd_pkg::CH_NUL
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Slow receiver, lightly idling sender. The drain in the middle of the
      // phase lets the block run completely empty before new bytes arrive.
      foreach (directed[i]) begin
         push_source(directed[i]);
      end
      queue_random_bytes(200);
      wait_drained();
      queue_random_bytes(200);
      wait_drained();

      // Slow sender, lightly stalling receiver.
      sender_idle_pct   = 88;
      receiver_idle_pct = 30;
      queue_random_bytes(400);
      wait_drained();

      // Full rate on both sides.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      queue_random_bytes(400);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && decoded_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
